// ===== hdl/fuzzy_scanline_matcher_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the scan line matcher.
// ----------------------------------------------------------------------------
`ifndef FUZZY_SCANLINE_MATCHER_MACROS_SVH
`define FUZZY_SCANLINE_MATCHER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FSLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define FSLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/fslm_pkg.sv =====
// ----------------------------------------------------------------------------
// fslm_pkg
// Types and fixed constants of the fuzzy scan line matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fslm_pkg;

  // Field widths.
  localparam int PIXEL_W = 32;
  localparam int CNT_W   = 11;
  localparam int RUN_W   = 12;
  localparam int PHASE_W = 3;

  // One sample every SAMPLE_STEP pixels, starting with the first.
  localparam int SAMPLE_STEP = 6;
  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(SAMPLE_STEP - 1);

  // A sample mismatches when |dR|+|dG|+|dB| exceeds this.
  localparam logic [9:0] DIFF_LIMIT = 10'd25;

  // Allowance is floor(samples / ALLOW_DIV) mismatches.
  localparam int ALLOW_DIV = 10;

  // Largest values the counters may hold.
  localparam int CNT_LIMIT = 2047;
  localparam int RUN_LIMIT = 4095;

  // Per-pixel flags captured at the input register.
  typedef struct packed {
    logic pix_eq;
    logic diff_over;
    logic last;
    logic restart;
  } pix_flags_t;

endpackage

// ===== hdl/fuzzy_scanline_matcher.sv =====
// ----------------------------------------------------------------------------
// fuzzy_scanline_matcher
// Exact and sampled fuzzy comparison of two scan lines, with a run counter.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per clock cycle while in_stall is low, and
// gives one result word per line, registered when the word with the line's
// last pixel leaves the input register. The rate is set by the line
// accumulator stage, which folds one pixel pair into the running counters
// each cycle unless a line-end word is held. A pending result that is stalled
// holds back only the next line-end word; pixel words keep flowing meanwhile.
`timescale 1ns / 1ps
`include "fuzzy_scanline_matcher_macros.svh"

module fuzzy_scanline_matcher #(
  parameter int MAX_LINE_PIXELS = 8192,
  parameter int RUN_MAX         = 4095
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [fslm_pkg::PIXEL_W-1:0]    pixel_a,
  input  logic [fslm_pkg::PIXEL_W-1:0]    pixel_b,
  input  logic                            last_pixel,
  input  logic                            first_of_run,
  // Output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            line_match,
  output logic                            exact_match,
  output logic [fslm_pkg::CNT_W-1:0]      mismatch_count,
  output logic [fslm_pkg::RUN_W-1:0]      run_length
);

  localparam int CntRaw = (MAX_LINE_PIXELS + fslm_pkg::SAMPLE_STEP - 1) /
                          fslm_pkg::SAMPLE_STEP;
  localparam int CntCapI = (CntRaw > fslm_pkg::CNT_LIMIT) ? fslm_pkg::CNT_LIMIT : CntRaw;
  localparam int RunCapI = (RUN_MAX > fslm_pkg::RUN_LIMIT) ? fslm_pkg::RUN_LIMIT : RUN_MAX;
  localparam logic [fslm_pkg::CNT_W-1:0] CNT_CAP = fslm_pkg::CNT_W'(CntCapI);
  localparam logic [fslm_pkg::RUN_W-1:0] RUN_CAP = fslm_pkg::RUN_W'(RunCapI);
  localparam int ProdW = fslm_pkg::CNT_W + 4;

  // Input register and handshake.
  logic                    s1_valid;
  fslm_pkg::pix_flags_t    s1;
  fslm_pkg::pix_flags_t    s1_next;
  logic                    out_free;
  logic                    s1_consume;
  logic                    in_take;

  // Line and run state.
  logic                          exact_so_far;
  logic [fslm_pkg::PHASE_W-1:0]  sample_phase;
  logic [fslm_pkg::CNT_W-1:0]    sample_total;
  logic [fslm_pkg::CNT_W-1:0]    mismatch_total;
  logic [fslm_pkg::RUN_W-1:0]    run_count;
  logic                          run_broken;

  // Combinational update values.
  logic [7:0]                    d_r;
  logic [7:0]                    d_g;
  logic [7:0]                    d_b;
  logic [9:0]                    d_sum;
  logic                          is_sample;
  logic                          exact_next;
  logic [fslm_pkg::CNT_W-1:0]    sample_next;
  logic [fslm_pkg::CNT_W-1:0]    mismatch_next;
  logic [ProdW-1:0]              mis_x10;
  logic                          match_now;
  logic [fslm_pkg::RUN_W-1:0]    run_base;
  logic                          broken_base;
  logic [fslm_pkg::RUN_W-1:0]    run_count_next;
  logic                          run_broken_next;

  // Handshake: pixel words always drain, line-end words need a free result slot.
  assign out_free   = !out_valid || !out_stall;
  assign s1_consume = s1_valid && (!s1.last || out_free);
  assign in_stall   = s1_valid && !s1_consume;
  assign in_take    = in_valid && !in_stall;

  // Per-channel absolute differences of R, G and B, alpha ignored.
  always_comb begin
    d_r = (pixel_a[23:16] >= pixel_b[23:16]) ? pixel_a[23:16] - pixel_b[23:16]
                                             : pixel_b[23:16] - pixel_a[23:16];
    d_g = (pixel_a[15:8] >= pixel_b[15:8]) ? pixel_a[15:8] - pixel_b[15:8]
                                           : pixel_b[15:8] - pixel_a[15:8];
    d_b = (pixel_a[7:0] >= pixel_b[7:0]) ? pixel_a[7:0] - pixel_b[7:0]
                                         : pixel_b[7:0] - pixel_a[7:0];
    d_sum = {2'b00, d_r} + {2'b00, d_g} + {2'b00, d_b};
    s1_next.pix_eq    = (pixel_a == pixel_b);
    s1_next.diff_over = (d_sum > fslm_pkg::DIFF_LIMIT);
    s1_next.last      = last_pixel;
    s1_next.restart   = first_of_run;
  end

  // Fold the registered pixel flags into the line counters.
  always_comb begin
    is_sample     = (sample_phase == '0);
    exact_next    = exact_so_far && s1.pix_eq;
    sample_next   = sample_total;
    mismatch_next = mismatch_total;
    if (is_sample && (sample_total < CNT_CAP)) begin
      sample_next = sample_total + 1'b1;
    end
    if (is_sample && s1.diff_over && (mismatch_total < CNT_CAP)) begin
      mismatch_next = mismatch_total + 1'b1;
    end
    // mismatches <= floor(samples/10) is the same as 10*mismatches <= samples.
    mis_x10   = ({4'b0000, mismatch_next} << 3) + ({4'b0000, mismatch_next} << 1);
    match_now = exact_next || (mis_x10 <= {4'b0000, sample_next});
  end

  // Run counter update for a line end.
  always_comb begin
    run_base        = s1.restart ? '0 : run_count;
    broken_base     = s1.restart ? 1'b0 : run_broken;
    run_count_next  = run_base;
    run_broken_next = broken_base;
    if (!broken_base) begin
      if (match_now) begin
        if (run_base < RUN_CAP) begin
          run_count_next = run_base + 1'b1;
        end
      end else begin
        run_broken_next = 1'b1;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_consume || !s1_valid) begin
      s1_valid <= in_take;
    end
    if (in_take) begin
      s1 <= s1_next;
    end
  end

  // Line accumulators and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      exact_so_far   <= 1'b1;
      sample_phase   <= '0;
      sample_total   <= '0;
      mismatch_total <= '0;
      run_count      <= '0;
      run_broken     <= 1'b0;
    end else if (s1_consume) begin
      if (s1.last) begin
        exact_so_far   <= 1'b1;
        sample_phase   <= '0;
        sample_total   <= '0;
        mismatch_total <= '0;
        run_count      <= run_count_next;
        run_broken     <= run_broken_next;
      end else begin
        exact_so_far   <= exact_next;
        sample_phase   <= (sample_phase == fslm_pkg::LAST_PHASE) ? '0
                                                                : sample_phase + 1'b1;
        sample_total   <= sample_next;
        mismatch_total <= mismatch_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_consume && s1.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_consume && s1.last) begin
      line_match     <= match_now;
      exact_match    <= exact_next;
      mismatch_count <= mismatch_next;
      run_length     <= run_count_next;
    end
  end

  // Checks on the internal state.
  `FSLM_ASSERT_NOW(a_phase_range, 1'b1, sample_phase <= fslm_pkg::LAST_PHASE, "sample phase out of range")
  `FSLM_ASSERT_NOW(a_mis_le_samples, 1'b1, mismatch_total <= sample_total, "more mismatches than samples")
  `FSLM_ASSERT_NOW(a_fail_breaks_run, out_valid && !line_match, run_broken, "failed line left run open")
  `FSLM_ASSERT_NEXT(a_line_end_held, s1_valid && s1.last && out_valid && out_stall, s1_valid, "line end word lost")
  `FSLM_ASSERT_NOW(a_exact_matches, out_valid && exact_match, line_match, "exact line reported as failing")

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fuzzy_scanline_matcher: it drives pixel pair words,
// predicts each line result in step with the accepted words and compares
// every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int LINE_PIXELS_MAX = 8192;
  localparam int RUN_SAT         = 4095;
  localparam int SAMPLES_RAW     = (LINE_PIXELS_MAX + fslm_pkg::SAMPLE_STEP - 1) /
                                   fslm_pkg::SAMPLE_STEP;
  localparam int COUNT_CAP       = (SAMPLES_RAW > fslm_pkg::CNT_LIMIT) ? fslm_pkg::CNT_LIMIT
                                                                       : SAMPLES_RAW;
  localparam int RUN_CAP         = (RUN_SAT > fslm_pkg::RUN_LIMIT) ? fslm_pkg::RUN_LIMIT
                                                                   : RUN_SAT;
  localparam int RANDOM_WORDS    = 1000;
  localparam int TAIL_WORDS      = 200;
  localparam int CYCLE_LIMIT     = 400000;

  // How the second pixel of a pair relates to the first.
  typedef enum int {
    PAIR_EQUAL,
    PAIR_ALPHA,
    PAIR_NEAR,
    PAIR_FAR
  } pair_kind_t;

  typedef struct packed {
    logic                       match;
    logic                       exact;
    logic [fslm_pkg::CNT_W-1:0] misses;
    logic [fslm_pkg::RUN_W-1:0] run;
  } line_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [fslm_pkg::PIXEL_W-1:0] pixel_a;
  logic [fslm_pkg::PIXEL_W-1:0] pixel_b;
  logic                         last_pixel;
  logic                         first_of_run;
  logic                         out_valid;
  logic                         out_stall;
  logic                         line_match;
  logic                         exact_match;
  logic [fslm_pkg::CNT_W-1:0]   mismatch_count;
  logic [fslm_pkg::RUN_W-1:0]   run_length;

  // Line and run state of the predictor.
  logic                         line_exact;
  logic [fslm_pkg::PHASE_W-1:0] line_phase;
  int                           line_samples;
  int                           line_misses;
  int                           run_total;
  logic                         run_frozen;

  line_result_t       expected_lines[$];

  logic               tx_gaps_on = 1'b0;
  logic               rx_gaps_on = 1'b0;
  int                 hold_left  = 0;
  int                 burst_left = 0;
  int                 fail_count = 0;
  int                 cycle_count = 0;

  fuzzy_scanline_matcher #(
    .MAX_LINE_PIXELS(LINE_PIXELS_MAX),
    .RUN_MAX        (RUN_SAT)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pixel_a       (pixel_a),
    .pixel_b       (pixel_b),
    .last_pixel    (last_pixel),
    .first_of_run  (first_of_run),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .line_match    (line_match),
    .exact_match   (exact_match),
    .mismatch_count(mismatch_count),
    .run_length    (run_length)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sum of absolute R, G and B differences; alpha does not count.
  function automatic int rgb_distance(logic [31:0] a, logic [31:0] b);
    int sum;
    int delta;
    sum = 0;
    for (int ch = 0; ch < 3; ch++) begin
      delta = int'(a[8*ch +: 8]) - int'(b[8*ch +: 8]);
      sum += (delta < 0) ? -delta : delta;
    end
    return sum;
  endfunction

  // Folds one accepted pixel pair into the line state and, on the last
  // pixel, queues the line result and updates the run.
  task automatic fold_pixel_pair(logic [31:0] a, logic [31:0] b, logic last,
                                 logic restart);
    line_result_t res;
    logic         hit;
    if (a != b) line_exact = 1'b0;
    if (line_phase == '0) begin
      if (line_samples < COUNT_CAP) line_samples++;
      if (rgb_distance(a, b) > int'(fslm_pkg::DIFF_LIMIT) && line_misses < COUNT_CAP)
        line_misses++;
    end
    line_phase = (line_phase == fslm_pkg::LAST_PHASE) ? '0 : line_phase + 1'b1;
    if (last) begin
      hit = line_exact || (line_misses <= line_samples / fslm_pkg::ALLOW_DIV);
      if (restart) begin
        run_total  = 0;
        run_frozen = 1'b0;
      end
      if (!run_frozen) begin
        if (hit) begin
          if (run_total < RUN_CAP) run_total++;
        end else begin
          run_frozen = 1'b1;
        end
      end
      res.match  = hit;
      res.exact  = line_exact;
      res.misses = fslm_pkg::CNT_W'(line_misses);
      res.run    = fslm_pkg::RUN_W'(run_total);
      expected_lines.push_back(res);
      line_exact   = 1'b1;
      line_phase   = '0;
      line_samples = 0;
      line_misses  = 0;
    end
  endtask

  // Offers one word and returns at the falling edge after it was taken.
  task automatic send_pixel_pair(logic [31:0] a, logic [31:0] b, logic last,
                                 logic restart);
    if (tx_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    pixel_a      = a;
    pixel_b      = b;
    last_pixel   = last;
    first_of_run = restart;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_pixel_pair(a, b, last, restart);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (expected_lines.size() != 0) @(negedge clk);
  endtask

  // Moves R, G and B away from the base pixel by about the given total.
  function automatic logic [31:0] shift_rgb(logic [31:0] a, int total);
    logic [31:0] b;
    int          left;
    int          part;
    int          c;
    b    = a;
    left = total;
    for (int ch = 0; ch < 3; ch++) begin
      part = (ch == 2) ? left : $urandom_range(0, (left > 255) ? 255 : left);
      if (part > 255) part = 255;
      c = int'(a[8*ch +: 8]);
      if (c + part <= 255) c = c + part;
      else if (c >= part) c = c - part;
      else if (c > 127) c = 0;
      else c = 255;
      b[8*ch +: 8] = 8'(c);
      left -= part;
    end
    if ($urandom_range(0, 1) == 1) b[31:24] = 8'($urandom);
    return b;
  endfunction

  function automatic logic [31:0] make_partner(logic [31:0] a, pair_kind_t kind);
    case (kind)
      PAIR_EQUAL: return a;
      PAIR_ALPHA: return {a[31:24] ^ 8'($urandom_range(1, 255)), a[23:0]};
      PAIR_NEAR:  return shift_rgb(a, ($urandom_range(0, 3) == 0) ? 25 : $urandom_range(1, 25));
      default:    return shift_rgb(a, ($urandom_range(0, 3) == 0) ? 26 : $urandom_range(26, 765));
    endcase
  endfunction

  // One line of random pixels; far_pct sets how many pairs differ strongly.
  task automatic send_random_line(int len, int far_pct, logic restart, logic exact_only);
    logic [31:0] a;
    pair_kind_t  kind;
    int          roll;
    for (int i = 0; i < len; i++) begin
      a    = $urandom;
      roll = $urandom_range(0, 99);
      if (exact_only) begin
        kind = PAIR_EQUAL;
      end else if (roll < far_pct) begin
        kind = PAIR_FAR;
      end else begin
        roll = $urandom_range(0, 9);
        kind = (roll < 6) ? PAIR_EQUAL : (roll < 8) ? PAIR_ALPHA : PAIR_NEAR;
      end
      send_pixel_pair(a, make_partner(a, kind), i == len - 1,
                      (i == len - 1) ? restart : 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver stall: a long hold when asked, else random bursts.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic report_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, what);
  endtask

  // Compare each taken result word with the oldest expected line.
  always @(posedge clk) begin : check_line_result
    line_result_t seen;
    line_result_t want;
    if (!rst && out_valid && !out_stall) begin
      seen.match  = line_match;
      seen.exact  = exact_match;
      seen.misses = mismatch_count;
      seen.run    = run_length;
      if (expected_lines.size() == 0) begin
        report_failure($sformatf("unexpected line result match=%0b exact=%0b misses=%0d run=%0d",
                                 seen.match, seen.exact, seen.misses, seen.run));
      end else begin
        want = expected_lines.pop_front();
        if (seen !== want)
          report_failure($sformatf({"line result differs: expected match=%0b exact=%0b ",
                                    "misses=%0d run=%0d, got match=%0b exact=%0b ",
                                    "misses=%0d run=%0d"},
                                   want.match, want.exact, want.misses, want.run,
                                   seen.match, seen.exact, seen.misses, seen.run));
      end
    end
  end

  // Field extremes, the 25/26 threshold, alpha, ignored inner run flags
  // and run restart, freeze and resume.
  task automatic test_directed_edges();
    send_pixel_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    send_pixel_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    // Alpha-only difference: not exact, but no sample mismatch.
    send_pixel_pair(32'hFF00_0000, 32'h0000_0000, 1'b1, 1'b0);
    // A difference of exactly 25, split over channels, and on red alone.
    send_pixel_pair(32'h0000_0000, 32'h000A_0A05, 1'b1, 1'b0);
    send_pixel_pair(32'h00FF_FFFF, 32'h00E6_FFFF, 1'b1, 1'b0);
    // One above the limit fails the line and freezes the run.
    send_pixel_pair(32'h0000_0000, 32'h001A_0000, 1'b1, 1'b0);
    send_pixel_pair(32'h00FF_FFFF, 32'hFF00_0000, 1'b1, 1'b0);
    send_pixel_pair(32'h1234_5678, 32'h1234_5678, 1'b1, 1'b0);
    // Seven pixels: only pixels 0 and 6 are samples, so strong differences
    // in between cost exactness only. Inner run flags are ignored.
    send_pixel_pair(32'h00AB_CDEF, 32'h00AB_CDEF, 1'b0, 1'b1);
    for (int i = 0; i < 5; i++)
      send_pixel_pair(32'h0000_0000, 32'h00FF_FFFF, 1'b0, 1'b1);
    send_pixel_pair(32'h8040_2010, 32'h8040_2010, 1'b1, 1'b0);
    // Restart on a failing line, then on a matching one.
    send_pixel_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1);
    send_pixel_pair(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1);
    drain_results();
  endtask

  // The receiver holds off while short lines keep coming, so the block
  // fills up and stalls its input.
  task automatic test_receiver_holdoff();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    hold_left  = 400;
    for (int n = 0; n < 30; n++)
      send_random_line($urandom_range(1, 4), 50, $urandom_range(0, 5) == 0, 1'b0);
    drain_results();
  endtask

  // The sender stops until every pending line result is out.
  task automatic test_sender_pause();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (3) begin
      repeat (4) send_random_line($urandom_range(1, 20), 20, 1'b0, 1'b0);
      drain_results();
    end
  endtask

  // Random lines, mostly short, with gaps switched on and off in stretches.
  task automatic test_random_lines();
    int far_rates[6] = '{0, 3, 10, 20, 50, 100};
    int sent;
    int len;
    int pick;
    sent       = 0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0) begin
        tx_gaps_on = ($urandom_range(0, 4) != 0);
        rx_gaps_on = ($urandom_range(0, 4) != 0);
      end
      pick = $urandom_range(0, 19);
      len  = (pick < 13) ? $urandom_range(1, 12) :
             (pick < 19) ? $urandom_range(13, 80) : $urandom_range(81, 300);
      send_random_line(len, far_rates[$urandom_range(0, 5)], $urandom_range(0, 4) == 0,
                       $urandom_range(0, 7) == 0);
      sent += len;
    end
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    drain_results();
  endtask

  // Short lines back to back with no idling on either side.
  task automatic test_back_to_back_lines();
    int sent;
    int len;
    sent       = 0;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    while (sent < TAIL_WORDS) begin
      len = $urandom_range(1, 12);
      send_random_line(len, 10, $urandom_range(0, 3) == 0, 1'b0);
      sent += len;
    end
    drain_results();
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    pixel_a      = '0;
    pixel_b      = '0;
    last_pixel   = 1'b0;
    first_of_run = 1'b0;
    line_exact   = 1'b1;
    line_phase   = '0;
    line_samples = 0;
    line_misses  = 0;
    run_total    = 0;
    run_frozen   = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_directed_edges();
    test_receiver_holdoff();
    test_sender_pause();
    test_random_lines();
    // No idling from here to the end.
    test_back_to_back_lines();

    in_valid = 1'b0;
    drain_results();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_lines.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
